// ===== sv/hds_pkg.sv =====
// ----------------------------------------------------------------------------
// hds_pkg
// Shared types and constants of the heat diffusion stencil.
// ----------------------------------------------------------------------------
package hds_pkg;

  localparam int COEF_W     = 16;
  localparam int FRAC_BITS  = 16;
  localparam int SIDE_W     = 7;
  localparam int POS_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [COEF_W-1:0] COEF_X_RESET = 16'd6554;
  localparam logic [COEF_W-1:0] COEF_Y_RESET = 16'd6554;
  localparam logic              CLAMP_RESET  = 1'b0;
  localparam logic [SIDE_W-1:0] SIDE_RESET   = 7'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_X         = 2'd0,
    REG_COEF_Y         = 2'd1,
    REG_CLAMP_NEGATIVE = 2'd2,
    REG_SIDE_LENGTH    = 2'd3
  } cfg_reg_t;

endpackage

// ===== sv/hds_if.sv =====
// ----------------------------------------------------------------------------
// hds interfaces
// Valid/ready channels of the heat diffusion stencil: cells, results, config.
// ----------------------------------------------------------------------------
interface hds_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] temperature;
  logic                          frame_start;

  modport source (output valid, output temperature, output frame_start, input ready);
  modport sink   (input valid, input temperature, input frame_start, output ready);
endinterface

interface hds_out_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                             valid;
  logic                             ready;
  logic [hds_pkg::POS_W-1:0]        cell_row;
  logic [hds_pkg::POS_W-1:0]        cell_col;
  logic signed [VALUE_WIDTH-1:0]    next_temperature;
  logic                             last_cell;

  modport source (output valid, output cell_row, output cell_col,
                  output next_temperature, output last_cell, input ready);
  modport sink   (input valid, input cell_row, input cell_col,
                  input next_temperature, input last_cell, output ready);
endinterface

interface hds_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hds_pkg::CFG_IDX_W-1:0]  index;
  logic [hds_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/hds_row_ram.sv =====
// ----------------------------------------------------------------------------
// hds_row_ram
// One-row line buffer: one write port, one registered read port, per-entry
// valid bits so unwritten entries read as zero, write-to-read bypass.
// ----------------------------------------------------------------------------
module hds_row_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] filled;
  logic [WIDTH-1:0] rd_raw;
  logic [WIDTH-1:0] byp_data;
  logic             byp_hit;
  logic             rd_filled;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (wr_en) begin
      filled[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw    <= mem[rd_addr];
      rd_filled <= filled[rd_addr];
      byp_hit   <= wr_en && (wr_addr == rd_addr);
      byp_data  <= wr_data;
    end
  end

  assign rd_data = byp_hit ? byp_data : (rd_filled ? rd_raw : '0);

endmodule

// ===== sv/heat_diffusion_stencil.sv =====
// ----------------------------------------------------------------------------
// heat_diffusion_stencil
// Streaming five-point stencil for the explicit 2-D heat equation.
//
// Usage:
//   cells   : grid temperatures (signed Q23.8) in raster order, frame_start
//             marks cell (0,0) of a grid; a grid wraps to (0,0) on its own.
//   results : next temperature of each interior cell with its row, column
//             and a last_cell flag; border cells give no item.
//   cfg     : register writes (coef_x, coef_y, clamp_negative, side_length),
//             always ready; written by the user only while the block is idle (not enforced).
// Throughput: one cell per cycle while the output is not stalled. The cell
//   below a centre enters the stage register, its result the output register.
// Two row buffers (upper and centre rows, the centre row kept twice for its
//   two read addresses) supply the stencil; the arithmetic sits between the
//   buffer read registers and the output register.
// Reset: counters go to (0,0), config to its defaults, both row buffers read
//   as zero until written (valid bits, no clearing pass).
// Stall: a held output keeps its item; cells that give no item still pass,
//   the next interior cell waits in the stage register, then cells.ready
//   drops until the output is taken.
// ----------------------------------------------------------------------------
module heat_diffusion_stencil #(
  parameter int MAX_SIDE    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input logic        clk,
  input logic        rst,
  hds_cfg_if.sink    cfg,
  hds_in_if.sink     cells,
  hds_out_if.source  results
);

  localparam int AW  = $clog2(MAX_SIDE);
  localparam int NW0 = $clog2(MAX_SIDE + 1);
  localparam int NW  = (NW0 > hds_pkg::SIDE_W) ? NW0 : hds_pkg::SIDE_W;
  localparam int VW  = VALUE_WIDTH;
  localparam int DW  = VW + 2;
  localparam int PW  = DW + hds_pkg::COEF_W + 1;
  localparam int QW  = PW - hds_pkg::FRAC_BITS;
  localparam int SW  = VW + 4;

  // config
  logic [hds_pkg::COEF_W-1:0] coef_x;
  logic [hds_pkg::COEF_W-1:0] coef_y;
  logic                       clamp_negative;
  logic [hds_pkg::SIDE_W-1:0] side_length;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x         <= hds_pkg::COEF_X_RESET;
      coef_y         <= hds_pkg::COEF_Y_RESET;
      clamp_negative <= hds_pkg::CLAMP_RESET;
      side_length    <= hds_pkg::SIDE_RESET;
    end else if (cfg.valid) begin
      unique case (hds_pkg::cfg_reg_t'(cfg.index))
        hds_pkg::REG_COEF_X:         coef_x         <= cfg.data;
        hds_pkg::REG_COEF_Y:         coef_y         <= cfg.data;
        hds_pkg::REG_CLAMP_NEGATIVE: clamp_negative <= cfg.data[0];
        hds_pkg::REG_SIDE_LENGTH:    side_length    <= cfg.data[hds_pkg::SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0] side_ext;
  logic [NW-1:0] side_n;

  always_comb begin
    side_ext = NW'(side_length);
    if (side_ext < NW'(3)) begin
      side_n = NW'(3);
    end else if (side_ext > NW'(MAX_SIDE)) begin
      side_n = NW'(MAX_SIDE);
    end else begin
      side_n = side_ext;
    end
  end

  // position tracking
  logic [AW-1:0] row_cnt;
  logic [AW-1:0] col_cnt;
  logic [AW-1:0] row_cnt_next;
  logic [AW-1:0] col_cnt_next;
  logic [AW-1:0] pos_row;
  logic [AW-1:0] pos_col;
  logic [NW-1:0] pr_ext;
  logic [NW-1:0] pc_ext;
  logic [NW-1:0] pr_inc;
  logic [NW-1:0] pc_inc;
  logic          restart;
  logic          pos_emit;
  logic          pos_last;
  logic          accept;

  assign accept = cells.valid && cells.ready;

  always_comb begin
    restart = cells.frame_start || (NW'(row_cnt) >= side_n) || (NW'(col_cnt) >= side_n);
    pos_row = restart ? '0 : row_cnt;
    pos_col = restart ? '0 : col_cnt;
    pr_ext  = NW'(pos_row);
    pc_ext  = NW'(pos_col);
    pr_inc  = pr_ext + NW'(1);
    pc_inc  = pc_ext + NW'(1);
    if (pc_inc >= side_n) begin
      col_cnt_next = '0;
      row_cnt_next = (pr_inc >= side_n) ? '0 : AW'(pr_inc);
    end else begin
      col_cnt_next = AW'(pc_inc);
      row_cnt_next = pos_row;
    end
    pos_emit = (pr_ext >= NW'(2)) && (pc_ext >= NW'(1)) && (pc_inc < side_n);
    pos_last = (pr_ext == side_n - NW'(1)) && (pc_ext == side_n - NW'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (accept) begin
      row_cnt <= row_cnt_next;
      col_cnt <= col_cnt_next;
    end
  end

  // stage register
  logic                 s1_valid;
  logic                 s1_adv;
  logic signed [VW-1:0] s1_x;
  logic [AW-1:0]        s1_row;
  logic [AW-1:0]        s1_col;
  logic                 s1_emit;
  logic                 s1_last;
  logic                 out_valid;

  assign s1_adv      = s1_valid && (!s1_emit || !out_valid || results.ready);
  assign cells.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x    <= cells.temperature;
      s1_row  <= pos_row;
      s1_col  <= pos_col;
      s1_emit <= pos_emit;
      s1_last <= pos_last;
    end
  end

  // row buffers
  logic [VW-1:0] u_q;
  logic [VW-1:0] up_q;
  logic [VW-1:0] right_q;

  hds_row_ram #(.DEPTH(MAX_SIDE), .WIDTH(VW)) u_upper_row (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (u_q),
    .rd_en   (accept),
    .rd_addr (pos_col),
    .rd_data (up_q)
  );

  hds_row_ram #(.DEPTH(MAX_SIDE), .WIDTH(VW)) u_centre_row (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (s1_x),
    .rd_en   (accept),
    .rd_addr (pos_col),
    .rd_data (u_q)
  );

  hds_row_ram #(.DEPTH(MAX_SIDE), .WIDTH(VW)) u_centre_right (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (s1_x),
    .rd_en   (accept),
    .rd_addr (AW'(pc_inc)),
    .rd_data (right_q)
  );

  logic signed [VW-1:0] left_prev;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_prev <= '0;
    end else if (s1_adv) begin
      left_prev <= u_q;
    end
  end

  // stencil arithmetic
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [PW-1:0] px;
  logic signed [PW-1:0] py;
  logic signed [QW-1:0] qx;
  logic signed [QW-1:0] qy;
  logic signed [SW-1:0] sum;
  logic signed [VW-1:0] sat;
  logic signed [VW-1:0] res;

  always_comb begin
    dx  = DW'($signed(up_q)) + DW'(s1_x) - (DW'($signed(u_q)) <<< 1);
    dy  = DW'(left_prev) + DW'($signed(right_q)) - (DW'($signed(u_q)) <<< 1);
    px  = dx * $signed({1'b0, coef_x});
    py  = dy * $signed({1'b0, coef_y});
    qx  = px[PW-1:hds_pkg::FRAC_BITS];
    qy  = py[PW-1:hds_pkg::FRAC_BITS];
    sum = SW'($signed(u_q)) + SW'(qx) + SW'(qy);
    if ((&sum[SW-1:VW-1]) || !(|sum[SW-1:VW-1])) begin
      sat = sum[VW-1:0];
    end else if (sum[SW-1]) begin
      sat = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(VW-1){1'b1}}};
    end
    res = (clamp_negative && sat[VW-1]) ? '0 : sat;
  end

  // output register
  logic [hds_pkg::POS_W-1:0] out_row;
  logic [hds_pkg::POS_W-1:0] out_col;
  logic signed [VW-1:0]      out_temp;
  logic                      out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      out_row  <= hds_pkg::POS_W'(s1_row - AW'(1));
      out_col  <= hds_pkg::POS_W'(s1_col);
      out_temp <= res;
      out_last <= s1_last;
    end
  end

  assign results.valid            = out_valid;
  assign results.cell_row         = out_row;
  assign results.cell_col         = out_col;
  assign results.next_temperature = out_temp;
  assign results.last_cell        = out_last;

endmodule

// ===== sv/hds_checker.sv =====
// ----------------------------------------------------------------------------
// hds_checker
// Port-level checks of the heat diffusion stencil, bound to the top level.
// ----------------------------------------------------------------------------
module hds_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [hds_pkg::POS_W-1:0]  cell_row,
  input logic [hds_pkg::POS_W-1:0]  cell_col,
  input logic [VALUE_WIDTH-1:0]     next_temperature,
  input logic                       last_cell
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({cell_row, cell_col, next_temperature, last_cell}))
    else $error("result payload changed while stalled");

  a_out_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without an item accepted two cycles before");

endmodule

bind heat_diffusion_stencil hds_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_hds_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (cells.valid),
  .in_ready         (cells.ready),
  .out_valid        (results.valid),
  .out_ready        (results.ready),
  .cell_row         (results.cell_row),
  .cell_col         (results.cell_col),
  .next_temperature (results.next_temperature),
  .last_cell        (results.last_cell)
);
